>>> rtl/nlqt_pkg.sv
// Shared types and constants of the neighbor link quality table.
`timescale 1ns / 1ps
package nlqt_pkg;

  // Shared divider: dividend and divisor widths, step counter width.
  localparam int DVD_W = 20;
  localparam int DVS_W = 8;
  localparam int DCNT_W = 5;

  localparam logic [15:0] SEED_METRIC = 16'h0111;
  localparam logic [15:0] METRIC_MAX = 16'hFFFF;
  localparam logic [7:0] TICKS_MAX = 8'hFF;

  // Reciprocal of five for 16-bit operands: (m * FIFTH_RECIP) >> 18 is m / 5.
  localparam logic [15:0] FIFTH_RECIP = 16'hCCCD;

  localparam logic [7:0] RST_UNIT = 8'd10;
  localparam logic [3:0] RST_MISSABLE = 4'd3;
  localparam logic [15:0] RST_MAX_INTERVAL = 16'd120;
  localparam logic [7:0] RST_DELTA = 8'd48;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    CFG_UNIT = 2'd0,
    CFG_MISSABLE = 2'd1,
    CFG_MAX_INTERVAL = 2'd2,
    CFG_DELTA = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_HANDLED = 2'd0,
    KIND_DROP = 2'd1,
    KIND_TICK = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    DIV_TICKS = 2'd0,
    DIV_METRIC = 2'd1
  } div_op_t;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SCAN_RD = 10'b0000000010,
    S_SCAN_CMP = 10'b0000000100,
    S_PREP = 10'b0000001000,
    S_WIN = 10'b0000010000,
    S_SHIFT = 10'b0000100000,
    S_DIV = 10'b0001000000,
    S_TK_RD = 10'b0010000000,
    S_TK_UPD = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

endpackage

>>> rtl/neighbor_link_quality_table_top.sv
// Neighbor link quality table: slot memory, lookup sequencer and shared divider.
// Packet request: a scan of the slots (one memory read and one compare per slot), a setup step,
//   a division for the beacon time of a beacon or a new sender, a window step, then for a known
//   sender up to HISTORY_BITS shift steps and a division for the metric; an emit step ends it.
//   A full table without a match goes straight to the emit step. One request is worked at a time.
// Tick request: a read step per empty slot; read, update and emit steps per live slot.
// Reset (synchronous, active low) clears valid bits, sequencer and registers; no clearing pass.
`timescale 1ns / 1ps
module neighbor_link_quality_table_top #(
  parameter int TABLE_SLOTS = 16,
  parameter int ADDR_BITS = 16,
  parameter int HISTORY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_neighbor_addr,
  input  logic        in_is_beacon,
  input  logic [15:0] in_beacon_interval_secs,
  input  logic [7:0]  in_mac_seqno,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_slot,
  output logic [15:0] out_entry_addr,
  output logic [15:0] out_link_metric,
  output logic        out_slot_valid,
  output logic        out_notify,
  output logic        out_evicted,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(2 * HISTORY_BITS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [HISTORY_BITS-1:0] HIST_TOP = {1'b1, {(HISTORY_BITS - 1){1'b0}}};

  typedef struct packed {
    logic [ADDR_BITS-1:0]    addr;
    logic [15:0]             metric;
    logic [HISTORY_BITS-1:0] hist;
    logic [CNT_W-1:0]        fail;
    logic [CNT_W-1:0]        succ;
    logic [7:0]              seq;
    logic [15:0]             reported;
    logic [7:0]              exp_ticks;
    logic [7:0]              ticks;
    logic [3:0]              misses;
  } entry_t;

  nlqt_pkg::state_t state_r;
  nlqt_pkg::div_op_t div_op_r;
  nlqt_pkg::kind_t out_kind_r;

  entry_t mem [TABLE_SLOTS];
  entry_t rd_q;
  entry_t ent_r;
  entry_t tk_ent;
  logic wr_en;

  logic [TABLE_SLOTS-1:0] valid_r;
  logic [SLOT_W-1:0] scan_r, slot_r, free_r;
  logic free_ok_r, fresh_r, full_r, tick_r, ev_r, notify_r;

  logic [ADDR_BITS-1:0] in_addr_r;
  logic in_beacon_r;
  logic [15:0] in_interval_r;
  logic [7:0] in_seq_r;

  logic [7:0] unit_r, delta_r;
  logic [3:0] missable_r;
  logic [15:0] max_interval_r;

  logic [nlqt_pkg::DVD_W-1:0] dvd_r;
  logic [nlqt_pkg::DVS_W-1:0] dvs_r;
  logic [nlqt_pkg::DVS_W-1:0] rem_r;
  logic [nlqt_pkg::DCNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_r;

  logic out_valid_r, out_slot_valid_r, out_notify_r, out_evicted_r, out_last_r;
  logic [3:0] out_slot_r;
  logic [15:0] out_addr_r, out_metric_r;

  // Helper signals
  logic [ADDR_BITS+15:0] in_addr_ext, ent_addr_ext;
  logic [SLOT_W+3:0] slot_ext;
  logic [7:0] losses;
  logic [9:0] w_sum;
  logic gap_big, win_over;
  logic [HISTORY_BITS-1:0] set_bit;
  logic [CNT_W-1:0] win_f, win_c, sh_f, sh_c, met_f, met_c;
  logic [HISTORY_BITS-1:0] sh_h;
  logic [nlqt_pkg::DVD_W-1:0] met_dvd, dq;
  logic [nlqt_pkg::DVS_W:0] rem_sh, rn;
  logic q_bit;
  logic [7:0] unit_eff, ticks_sat;
  logic [15:0] m_new, scale_sat;
  logic [31:0] fifth_prod;
  logic [16:0] scale_sum;
  logic notify_now, later_v, emit_go;
  logic [7:0] tk_ticks;
  logic [3:0] tk_misses;

  assign in_ready = (state_r == nlqt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_go = (state_r == nlqt_pkg::S_EMIT) && (!out_valid_r || out_ready);
  assign wr_en = emit_go && !full_r;

  // Slot memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[slot_r] <= ent_r;
    end
    rd_q <= mem[scan_r];
  end

  assign in_addr_ext = {{ADDR_BITS{1'b0}}, in_neighbor_addr};
  assign ent_addr_ext = {16'h0000, ent_r.addr};
  assign slot_ext = {4'h0, slot_r};

  assign losses = in_seq_r - ent_r.seq - 8'd1;
  assign w_sum = 10'(ent_r.fail) + 10'(ent_r.succ) + 10'(losses);
  assign gap_big = (10'(losses) >= 10'(HISTORY_BITS));
  assign win_over = (w_sum >= 10'(HISTORY_BITS));

  always_comb begin
    for (int i = 0; i < HISTORY_BITS; i++) begin
      set_bit[i] = (w_sum == 10'(i));
    end
  end

  assign win_f = gap_big ? CNT_W'(HISTORY_BITS - 1) : ent_r.fail + CNT_W'(losses);
  assign win_c = gap_big ? CNT_W'(1) : ent_r.succ + CNT_W'(1);

  // One window shift step: the oldest bit leaves and its count drops.
  assign sh_h = ent_r.hist >> 1;
  assign sh_c = ent_r.hist[0] ? ent_r.succ - CNT_W'(1) : ent_r.succ;
  assign sh_f = ent_r.hist[0] ? ent_r.fail : ent_r.fail - CNT_W'(1);

  assign met_f = (state_r == nlqt_pkg::S_SHIFT) ? sh_f : win_f;
  assign met_c = (state_r == nlqt_pkg::S_SHIFT) ? sh_c : win_c;
  assign met_dvd = nlqt_pkg::DVD_W'({met_f, 8'h00}) - nlqt_pkg::DVD_W'(met_f);

  // A missed beacon scales the metric by 6/5, written as m + m/5.
  assign fifth_prod = 32'(rd_q.metric) * 32'(nlqt_pkg::FIFTH_RECIP);
  assign scale_sum = {1'b0, rd_q.metric} + 17'(fifth_prod[31:18]);
  assign scale_sat = scale_sum[16] ? nlqt_pkg::METRIC_MAX : scale_sum[15:0];

  assign unit_eff = (unit_r == 8'd0) ? 8'd1 : unit_r;

  // Restoring divider step.
  assign rem_sh = {rem_r, dvd_r[nlqt_pkg::DVD_W-1]};
  assign q_bit = (rem_sh >= {1'b0, dvs_r});
  assign rn = q_bit ? rem_sh - {1'b0, dvs_r} : rem_sh;
  assign dq = {dvd_r[nlqt_pkg::DVD_W-2:0], q_bit};

  assign ticks_sat = (dq >= nlqt_pkg::DVD_W'(nlqt_pkg::TICKS_MAX)) ? nlqt_pkg::TICKS_MAX :
                     8'(dq) + 8'd1;
  assign m_new = 16'(dq) + 16'd1;
  assign notify_now = ({2'b00, m_new} > {2'b00, ent_r.reported} + 18'(delta_r)) ||
                      ({2'b00, m_new} + 18'(delta_r) < {2'b00, ent_r.reported});

  always_comb begin
    later_v = 1'b0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (valid_r[i] && (i > int'(scan_r))) begin
        later_v = 1'b1;
      end
    end
  end

  assign tk_ticks = rd_q.ticks - 8'd1;
  assign tk_misses = rd_q.misses - 4'd1;

  // Entry after one tick: the metric is scaled only when the slot survives the miss.
  always_comb begin
    tk_ent = rd_q;
    if (tk_ticks == 8'd0) begin
      tk_ent.ticks = rd_q.exp_ticks;
      tk_ent.misses = tk_misses;
      if (tk_misses != 4'd0) begin
        tk_ent.metric = scale_sat;
      end
    end else begin
      tk_ent.ticks = tk_ticks;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r <= nlqt_pkg::RST_UNIT;
      missable_r <= nlqt_pkg::RST_MISSABLE;
      max_interval_r <= nlqt_pkg::RST_MAX_INTERVAL;
      delta_r <= nlqt_pkg::RST_DELTA;
    end else if (cfg_valid && cfg_ready) begin
      unique case (nlqt_pkg::cfg_idx_t'(cfg_index))
        nlqt_pkg::CFG_UNIT: unit_r <= cfg_data[7:0];
        nlqt_pkg::CFG_MISSABLE: missable_r <= cfg_data[3:0];
        nlqt_pkg::CFG_MAX_INTERVAL: max_interval_r <= cfg_data;
        nlqt_pkg::CFG_DELTA: delta_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_addr_r <= in_addr_ext[ADDR_BITS-1:0];
      in_beacon_r <= in_is_beacon;
      in_interval_r <= in_beacon_interval_secs;
      in_seq_r <= in_mac_seqno;
    end
    unique case (state_r)
      nlqt_pkg::S_SCAN_CMP: begin
        if (valid_r[scan_r] && rd_q.addr == in_addr_r) begin
          ent_r <= rd_q;
          slot_r <= scan_r;
        end else if (scan_r == LAST_SLOT) begin
          slot_r <= free_ok_r ? free_r : scan_r;
          ent_r.addr <= in_addr_r;
        end
        if (!valid_r[scan_r] && !free_ok_r) begin
          free_r <= scan_r;
        end
      end
      nlqt_pkg::S_PREP: begin
        dvs_r <= unit_eff;
        rem_r <= '0;
        cnt_r <= nlqt_pkg::DCNT_W'(nlqt_pkg::DVD_W);
        div_op_r <= nlqt_pkg::DIV_TICKS;
        dvd_r <= nlqt_pkg::DVD_W'(in_beacon_r ? in_interval_r : max_interval_r);
      end
      nlqt_pkg::S_WIN: begin
        ent_r.ticks <= ent_r.exp_ticks;
        ent_r.misses <= missable_r;
        ent_r.seq <= in_seq_r;
        if (fresh_r) begin
          ent_r.addr <= in_addr_r;
          ent_r.metric <= nlqt_pkg::SEED_METRIC;
          ent_r.reported <= nlqt_pkg::SEED_METRIC;
          ent_r.hist <= '0;
          ent_r.fail <= '0;
          ent_r.succ <= '0;
        end else begin
          ent_r.fail <= win_f;
          ent_r.succ <= win_c;
          n_r <= CNT_W'(losses) + CNT_W'(1);
          if (gap_big) begin
            ent_r.hist <= HIST_TOP;
          end else if (!win_over) begin
            ent_r.hist <= ent_r.hist | set_bit;
          end
          dvd_r <= met_dvd;
          dvs_r <= nlqt_pkg::DVS_W'(met_f + met_c);
          rem_r <= '0;
          cnt_r <= nlqt_pkg::DCNT_W'(nlqt_pkg::DVD_W);
          div_op_r <= nlqt_pkg::DIV_METRIC;
        end
      end
      nlqt_pkg::S_SHIFT: begin
        ent_r.fail <= sh_f;
        ent_r.succ <= sh_c;
        ent_r.hist <= (n_r == CNT_W'(1)) ? (sh_h | HIST_TOP) : sh_h;
        n_r <= n_r - CNT_W'(1);
        dvd_r <= met_dvd;
        dvs_r <= nlqt_pkg::DVS_W'(met_f + met_c);
        rem_r <= '0;
        cnt_r <= nlqt_pkg::DCNT_W'(nlqt_pkg::DVD_W);
      end
      nlqt_pkg::S_DIV: begin
        dvd_r <= dq;
        rem_r <= rn[nlqt_pkg::DVS_W-1:0];
        cnt_r <= cnt_r - nlqt_pkg::DCNT_W'(1);
        if (cnt_r == nlqt_pkg::DCNT_W'(1)) begin
          unique case (div_op_r)
            nlqt_pkg::DIV_TICKS: ent_r.exp_ticks <= ticks_sat;
            nlqt_pkg::DIV_METRIC: begin
              ent_r.metric <= m_new;
              if (notify_now) begin
                ent_r.reported <= m_new;
              end
            end
            default: ;
          endcase
        end
      end
      nlqt_pkg::S_TK_UPD: begin
        ent_r <= tk_ent;
        slot_r <= scan_r;
      end
      default: ;
    endcase
    if (emit_go) begin
      out_kind_r <= tick_r ? nlqt_pkg::KIND_TICK :
                    (full_r ? nlqt_pkg::KIND_DROP : nlqt_pkg::KIND_HANDLED);
      out_slot_r <= full_r ? 4'h0 : slot_ext[3:0];
      out_addr_r <= ent_addr_ext[15:0];
      out_metric_r <= full_r ? 16'h0000 : ent_r.metric;
      out_slot_valid_r <= tick_r ? !ev_r : !full_r;
      out_notify_r <= tick_r ? ev_r : notify_r;
      out_evicted_r <= tick_r && ev_r;
      out_last_r <= tick_r ? !later_v : 1'b1;
    end
  end

  // Control: sequencer state, valid bits, flags and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlqt_pkg::S_IDLE;
      valid_r <= '0;
      scan_r <= '0;
      free_ok_r <= 1'b0;
      fresh_r <= 1'b0;
      full_r <= 1'b0;
      tick_r <= 1'b0;
      ev_r <= 1'b0;
      notify_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        nlqt_pkg::S_IDLE: begin
          if (in_valid) begin
            scan_r <= '0;
            free_ok_r <= 1'b0;
            fresh_r <= 1'b0;
            full_r <= 1'b0;
            ev_r <= 1'b0;
            notify_r <= 1'b0;
            tick_r <= (in_cmd == nlqt_pkg::CMD_TICK);
            state_r <= (in_cmd == nlqt_pkg::CMD_TICK) ? nlqt_pkg::S_TK_RD :
                       nlqt_pkg::S_SCAN_RD;
          end
        end
        nlqt_pkg::S_SCAN_RD: state_r <= nlqt_pkg::S_SCAN_CMP;
        nlqt_pkg::S_SCAN_CMP: begin
          if (!valid_r[scan_r]) begin
            free_ok_r <= 1'b1;
          end
          if (valid_r[scan_r] && rd_q.addr == in_addr_r) begin
            state_r <= nlqt_pkg::S_PREP;
          end else if (scan_r == LAST_SLOT) begin
            if (free_ok_r || !valid_r[scan_r]) begin
              fresh_r <= 1'b1;
              state_r <= nlqt_pkg::S_PREP;
            end else begin
              full_r <= 1'b1;
              state_r <= nlqt_pkg::S_EMIT;
            end
          end else begin
            scan_r <= scan_r + SLOT_W'(1);
            state_r <= nlqt_pkg::S_SCAN_RD;
          end
        end
        nlqt_pkg::S_PREP: begin
          state_r <= (in_beacon_r || fresh_r) ? nlqt_pkg::S_DIV : nlqt_pkg::S_WIN;
        end
        nlqt_pkg::S_WIN: begin
          if (fresh_r) begin
            valid_r[slot_r] <= 1'b1;
            state_r <= nlqt_pkg::S_EMIT;
          end else if (!gap_big && win_over) begin
            state_r <= nlqt_pkg::S_SHIFT;
          end else begin
            state_r <= nlqt_pkg::S_DIV;
          end
        end
        nlqt_pkg::S_SHIFT: begin
          if (n_r == CNT_W'(1)) begin
            state_r <= nlqt_pkg::S_DIV;
          end
        end
        nlqt_pkg::S_DIV: begin
          if (cnt_r == nlqt_pkg::DCNT_W'(1)) begin
            if (div_op_r == nlqt_pkg::DIV_TICKS) begin
              state_r <= nlqt_pkg::S_WIN;
            end else begin
              notify_r <= notify_now;
              state_r <= nlqt_pkg::S_EMIT;
            end
          end
        end
        nlqt_pkg::S_TK_RD: begin
          ev_r <= 1'b0;
          if (valid_r[scan_r]) begin
            state_r <= nlqt_pkg::S_TK_UPD;
          end else if (scan_r == LAST_SLOT) begin
            state_r <= nlqt_pkg::S_IDLE;
          end else begin
            scan_r <= scan_r + SLOT_W'(1);
          end
        end
        nlqt_pkg::S_TK_UPD: begin
          if (tk_ticks == 8'd0 && tk_misses == 4'd0) begin
            valid_r[scan_r] <= 1'b0;
            ev_r <= 1'b1;
          end
          state_r <= nlqt_pkg::S_EMIT;
        end
        nlqt_pkg::S_EMIT: begin
          if (emit_go) begin
            if (tick_r && scan_r != LAST_SLOT) begin
              scan_r <= scan_r + SLOT_W'(1);
              state_r <= nlqt_pkg::S_TK_RD;
            end else begin
              state_r <= nlqt_pkg::S_IDLE;
            end
          end
        end
        default: state_r <= nlqt_pkg::S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_slot = out_slot_r;
  assign out_entry_addr = out_addr_r;
  assign out_link_metric = out_metric_r;
  assign out_slot_valid = out_slot_valid_r;
  assign out_notify = out_notify_r;
  assign out_evicted = out_evicted_r;
  assign out_last = out_last_r;

  a_evict_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (out_notify && !out_slot_valid))
    else $error("evicted result without notify or with a live slot");

  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == nlqt_pkg::KIND_DROP) |-> (out_last && !out_slot_valid))
    else $error("dropped request result is malformed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nlqt_pkg::S_DIV) |-> (cnt_r != '0))
    else $error("divider running with an empty step count");

endmodule
